// File: design/assert_macros.svh
// assertion helpers used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/tpd_pkg.sv
`timescale 1ns / 1ps

package tpd_pkg;

	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_MAX_QUERIES = 64;
	localparam int DEF_LENGTH_BITS = 16;

	localparam int NODE_W     = 10;
	localparam int LEN_W      = 16;
	localparam int OP_W       = 2;
	localparam int DIST_W     = 26;
	localparam int QIDX_W     = 6;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd3;

	typedef struct packed {
		logic in_load;
		logic clr_all;
		logic clr_valid;
		logic sweep;
		logic sweep_heads;
		logic side_b;
		logic edge_rd;
		logic edge_wr;
		logic qry_rd;
		logic qry_wr;
		logic init_rd;
		logic init_wr;
		logic stk_rd;
		logic top_ld;
		logic edge_fetch;
		logic edge_take;
		logic visit;
		logic push;
		logic pop;
		logic qh_rd;
		logic qh_take;
		logic q_rd;
		logic q_take;
		logic root_step;
		logic cmp_rd;
		logic cmp_wr;
		logic dx_rd;
		logic do_rd;
		logic dl_rd;
		logic ans_wr;
		logic par_wr;
		logic em_init;
		logic em_rd;
		logic em_ld;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            in_ok;
		logic            seen;
		logic            parent_is_r;
		logic            cx_is_r;
		logic            more;
		logic            top_full;
		logic            top_zero;
		logic            has;
		logic            sweep_last;
		logic            q_empty;
		logic            em_last;
		logic            out_free;
	} status_t;

endpackage

// File: design/tpd_ctrl.sv
`timescale 1ns / 1ps

module tpd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  tpd_pkg::status_t status,
	output tpd_pkg::cmd_t    cmd
);

	localparam logic [4:0] ST_SWEEP_ALL  = 5'd0;
	localparam logic [4:0] ST_IDLE       = 5'd1;
	localparam logic [4:0] ST_E_RDA      = 5'd2;
	localparam logic [4:0] ST_E_WRA      = 5'd3;
	localparam logic [4:0] ST_E_RDB      = 5'd4;
	localparam logic [4:0] ST_E_WRB      = 5'd5;
	localparam logic [4:0] ST_Q_RDA      = 5'd6;
	localparam logic [4:0] ST_Q_WRA      = 5'd7;
	localparam logic [4:0] ST_Q_RDB      = 5'd8;
	localparam logic [4:0] ST_Q_WRB      = 5'd9;
	localparam logic [4:0] ST_SWEEP_SEEN = 5'd10;
	localparam logic [4:0] ST_R_INIT     = 5'd11;
	localparam logic [4:0] ST_R_INIT2    = 5'd12;
	localparam logic [4:0] ST_W_RD       = 5'd13;
	localparam logic [4:0] ST_W_TOP      = 5'd14;
	localparam logic [4:0] ST_W_EFETCH   = 5'd15;
	localparam logic [4:0] ST_W_ETAKE    = 5'd16;
	localparam logic [4:0] ST_W_NODE     = 5'd17;
	localparam logic [4:0] ST_W_PUSH     = 5'd18;
	localparam logic [4:0] ST_F_HEAD     = 5'd19;
	localparam logic [4:0] ST_F_HTAKE    = 5'd20;
	localparam logic [4:0] ST_F_QCHK     = 5'd21;
	localparam logic [4:0] ST_F_QTAKE    = 5'd22;
	localparam logic [4:0] ST_F_SEEN     = 5'd23;
	localparam logic [4:0] ST_F_ROOT     = 5'd24;
	localparam logic [4:0] ST_C_CHK      = 5'd25;
	localparam logic [4:0] ST_C_WR       = 5'd26;
	localparam logic [4:0] ST_D_X        = 5'd27;
	localparam logic [4:0] ST_D_O        = 5'd28;
	localparam logic [4:0] ST_D_L        = 5'd29;
	localparam logic [4:0] ST_D_SUB      = 5'd30;
	localparam logic [4:0] ST_F_PAR      = 5'd31;

	logic [4:0] state_q, state_d;
	// the parent write after a pop and the start of the answer read-out share one state by phase
	logic       phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP_ALL;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		phase_d  = phase_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_SWEEP_ALL: begin
				cmd.sweep       = 1'b1;
				cmd.sweep_heads = 1'b1;
				if (status.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.in_load = 1'b1;
					unique case (status.op)
						tpd_pkg::OP_CLEAR: begin
							cmd.clr_all = 1'b1;
							state_d     = ST_SWEEP_ALL;
						end
						tpd_pkg::OP_EDGE: begin
							if (status.in_ok) state_d = ST_E_RDA;
						end
						tpd_pkg::OP_QUERY: begin
							if (status.in_ok) state_d = ST_Q_RDA;
						end
						tpd_pkg::OP_RUN: begin
							cmd.clr_valid = 1'b1;
							state_d       = ST_SWEEP_SEEN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_E_RDA: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_E_WRA;
			end
			ST_E_WRA: begin
				cmd.edge_wr = 1'b1;
				state_d     = ST_E_RDB;
			end
			ST_E_RDB: begin
				cmd.edge_rd = 1'b1;
				cmd.side_b  = 1'b1;
				state_d     = ST_E_WRB;
			end
			ST_E_WRB: begin
				cmd.edge_wr = 1'b1;
				cmd.side_b  = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_Q_RDA: begin
				cmd.qry_rd = 1'b1;
				state_d    = ST_Q_WRA;
			end
			ST_Q_WRA: begin
				cmd.qry_wr = 1'b1;
				state_d    = ST_Q_RDB;
			end
			ST_Q_RDB: begin
				cmd.qry_rd = 1'b1;
				cmd.side_b = 1'b1;
				state_d    = ST_Q_WRB;
			end
			ST_Q_WRB: begin
				cmd.qry_wr = 1'b1;
				cmd.side_b = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SWEEP_SEEN: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) state_d = ST_R_INIT;
			end
			ST_R_INIT: begin
				cmd.init_rd = 1'b1;
				state_d     = ST_R_INIT2;
			end
			ST_R_INIT2: begin
				cmd.init_wr = 1'b1;
				state_d     = ST_W_RD;
			end
			ST_W_RD: begin
				cmd.stk_rd = 1'b1;
				state_d    = ST_W_TOP;
			end
			ST_W_TOP: begin
				cmd.top_ld = 1'b1;
				state_d    = status.more ? ST_W_EFETCH : ST_F_HEAD;
			end
			ST_W_EFETCH: begin
				cmd.edge_fetch = 1'b1;
				state_d        = ST_W_ETAKE;
			end
			ST_W_ETAKE: begin
				cmd.edge_take = 1'b1;
				state_d       = ST_W_NODE;
			end
			ST_W_NODE: begin
				if (!status.seen && !status.top_full) begin
					cmd.visit = 1'b1;
					state_d   = ST_W_PUSH;
				end else begin
					state_d = ST_W_RD;
				end
			end
			ST_W_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_W_RD;
			end
			ST_F_HEAD: begin
				cmd.qh_rd = 1'b1;
				state_d   = ST_F_HTAKE;
			end
			ST_F_HTAKE: begin
				cmd.qh_take = 1'b1;
				state_d     = ST_F_QCHK;
			end
			ST_F_QCHK: begin
				if (status.has) begin
					cmd.q_rd = 1'b1;
					state_d  = ST_F_QTAKE;
				end else begin
					cmd.pop = 1'b1;
					phase_d = 1'b0;
					state_d = ST_F_PAR;
				end
			end
			ST_F_QTAKE: begin
				cmd.q_take = 1'b1;
				state_d    = ST_F_SEEN;
			end
			ST_F_SEEN: begin
				state_d = status.seen ? ST_F_ROOT : ST_F_QCHK;
			end
			ST_F_ROOT: begin
				if (status.parent_is_r) begin
					state_d = ST_C_CHK;
				end else begin
					cmd.root_step = 1'b1;
				end
			end
			ST_C_CHK: begin
				if (status.cx_is_r) begin
					state_d = ST_D_X;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d    = ST_C_WR;
				end
			end
			ST_C_WR: begin
				cmd.cmp_wr = 1'b1;
				state_d    = ST_C_CHK;
			end
			ST_D_X: begin
				cmd.dx_rd = 1'b1;
				state_d   = ST_D_O;
			end
			ST_D_O: begin
				cmd.do_rd = 1'b1;
				state_d   = ST_D_L;
			end
			ST_D_L: begin
				cmd.dl_rd = 1'b1;
				state_d   = ST_D_SUB;
			end
			ST_D_SUB: begin
				cmd.ans_wr = 1'b1;
				state_d    = ST_F_QCHK;
			end
			ST_F_PAR: begin
				// phase 0: fetch new top or start read-out, phase 1: link finished node
				if (!phase_q) begin
					if (status.top_zero) begin
						cmd.em_init = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						cmd.stk_rd = 1'b1;
						phase_d    = 1'b1;
					end
				end else begin
					cmd.par_wr = 1'b1;
					state_d    = ST_W_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/tpd_emit.sv
`timescale 1ns / 1ps

module tpd_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run_done,
	input  logic             q_empty,
	input  logic             em_last,
	input  logic             out_free,
	output logic             busy,
	output tpd_pkg::cmd_t    cmd
);

	localparam logic [1:0] EM_IDLE = 2'd0;
	localparam logic [1:0] EM_RD   = 2'd1;
	localparam logic [1:0] EM_LD   = 2'd2;

	logic [1:0] em_q, em_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_q <= EM_IDLE;
		end else begin
			em_q <= em_d;
		end
	end

	// per answer: registered read of the answer store, then load once the output is free
	always_comb begin
		cmd  = '0;
		em_d = em_q;
		unique case (em_q)
			EM_IDLE: begin
				if (run_done && !q_empty) em_d = EM_RD;
			end
			EM_RD: begin
				cmd.em_rd = 1'b1;
				em_d      = EM_LD;
			end
			EM_LD: begin
				if (out_free) begin
					cmd.em_ld = 1'b1;
					em_d      = em_last ? EM_IDLE : EM_RD;
				end
			end
			default: em_d = EM_IDLE;
		endcase
	end

	assign busy = (em_q != EM_IDLE);

endmodule

// File: design/tpd_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpd_datapath #(
	parameter int MAX_NODES   = tpd_pkg::DEF_MAX_NODES,
	parameter int MAX_QUERIES = tpd_pkg::DEF_MAX_QUERIES,
	parameter int LENGTH_BITS = tpd_pkg::DEF_LENGTH_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tpd_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [tpd_pkg::OP_W-1:0]        s_tuser,
	input  tpd_pkg::cmd_t                   cmd,
	output tpd_pkg::status_t                status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tpd_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int NIW        = $clog2(MAX_NODES);
	localparam int EDGE_SLOTS = 2 * MAX_NODES;
	localparam int EW         = $clog2(EDGE_SLOTS);
	localparam int ECW        = $clog2(EDGE_SLOTS + 1);
	localparam int TW         = $clog2(MAX_NODES + 1);
	localparam int QNW        = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
	localparam int QSW        = QNW + 1;
	localparam int QCW        = $clog2(MAX_QUERIES + 1);
	localparam int QSLOTS     = 2 * MAX_QUERIES;
	localparam int LB         = LENGTH_BITS;
	localparam int DW         = tpd_pkg::DIST_W;
	localparam int FW         = tpd_pkg::NODE_W;

	// input fields
	logic [FW-1:0]               in_a, in_b;
	logic [tpd_pkg::LEN_W-1:0]   in_len;
	logic                        a_ok, b_ok, edge_room, q_room;

	assign in_a   = s_tdata[9:0];
	assign in_b   = s_tdata[19:10];
	assign in_len = s_tdata[35:20];

	// control registers
	logic [ECW-1:0]          edge_cnt_q;
	logic [QCW-1:0]          q_cnt_q;
	logic [NIW-1:0]          sweep_q;
	logic [TW-1:0]           top_q;
	logic [MAX_QUERIES-1:0]  ans_valid_q;
	logic [QCW-1:0]          em_i_q;
	logic                    has_q;
	logic                    out_valid_q;

	// payload registers
	logic [NIW-1:0] a_q, b_q, x_q, v_q, o_q, r_q, cx_q;
	logic [LB-1:0]  w_q;
	logic [EW-1:0]  e_q;
	logic [QSW-1:0] q_q;
	logic [QNW-1:0] n_q;
	logic [DW-1:0]  acc_q;
	logic [tpd_pkg::QIDX_W-1:0] out_idx_q;
	logic [DW-1:0]  out_dist_q;
	logic           out_ans_q, out_last_q;

	// memories
	logic           head_used_m [MAX_NODES];
	logic [EW-1:0]  head_idx_m  [MAX_NODES];
	logic [NIW-1:0] edge_v_m    [EDGE_SLOTS];
	logic [LB-1:0]  edge_w_m    [EDGE_SLOTS];
	logic [EW-1:0]  edge_link_m [EDGE_SLOTS];
	logic           edge_used_m [EDGE_SLOTS];
	logic           qh_used_m   [MAX_NODES];
	logic [QSW-1:0] qh_slot_m   [MAX_NODES];
	logic [NIW-1:0] qo_m        [QSLOTS];
	logic [QNW-1:0] qn_m        [QSLOTS];
	logic [QSW-1:0] qlink_m     [QSLOTS];
	logic           qused_m     [QSLOTS];
	logic           node_seen_m [MAX_NODES];
	logic [NIW-1:0] node_par_m  [MAX_NODES];
	logic [DW-1:0]  dist_m      [MAX_NODES];
	logic [NIW-1:0] stk_node_m  [MAX_NODES];
	logic [EW-1:0]  stk_edge_m  [MAX_NODES];
	logic           stk_more_m  [MAX_NODES];
	logic [DW-1:0]  ans_m       [MAX_QUERIES];

	// read data registers
	logic           head_used_r, edge_used_r, qh_used_r, qused_r, node_seen_r, stk_more_r;
	logic [EW-1:0]  head_idx_r, edge_link_r, stk_edge_r;
	logic [NIW-1:0] edge_v_r, qo_r, node_par_r, stk_node_r;
	logic [LB-1:0]  edge_w_r;
	logic [QSW-1:0] qh_slot_r, qlink_r;
	logic [QNW-1:0] qn_r;
	logic [DW-1:0]  dist_r, ans_r;

	logic [NIW-1:0] side_from, side_to;
	logic [QSW-1:0] q_slot;
	logic [NIW-1:0] stk_top1;

	assign side_from = cmd.side_b ? b_q : a_q;
	assign side_to   = cmd.side_b ? a_q : b_q;
	assign q_slot    = {QNW'(q_cnt_q), cmd.side_b};
	assign stk_top1  = NIW'(top_q - TW'(1));

	// adjacency heads
	logic           head_we, head_re;
	logic [NIW-1:0] head_wa, head_ra;

	assign head_we = cmd.edge_wr | (cmd.sweep & cmd.sweep_heads);
	assign head_wa = cmd.sweep ? sweep_q : side_from;
	assign head_re = cmd.edge_rd | cmd.init_rd | cmd.visit;
	assign head_ra = cmd.init_rd ? NIW'(1) : (cmd.visit ? v_q : side_from);

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_used_m[head_wa] <= !cmd.sweep;
			head_idx_m[head_wa]  <= EW'(edge_cnt_q);
		end
		if (head_re) begin
			head_used_r <= head_used_m[head_ra];
			head_idx_r  <= head_idx_m[head_ra];
		end
	end

	// edge slots
	always_ff @(posedge clk) begin
		if (cmd.edge_wr) begin
			edge_v_m[EW'(edge_cnt_q)]    <= side_to;
			edge_w_m[EW'(edge_cnt_q)]    <= w_q;
			edge_link_m[EW'(edge_cnt_q)] <= head_idx_r;
			edge_used_m[EW'(edge_cnt_q)] <= head_used_r;
		end
		if (cmd.edge_fetch) begin
			edge_v_r    <= edge_v_m[e_q];
			edge_w_r    <= edge_w_m[e_q];
			edge_link_r <= edge_link_m[e_q];
			edge_used_r <= edge_used_m[e_q];
		end
	end

	// query list heads
	logic           qh_we, qh_re;
	logic [NIW-1:0] qh_wa, qh_ra;

	assign qh_we = cmd.qry_wr | (cmd.sweep & cmd.sweep_heads);
	assign qh_wa = cmd.sweep ? sweep_q : side_from;
	assign qh_re = cmd.qry_rd | cmd.qh_rd;
	assign qh_ra = cmd.qh_rd ? x_q : side_from;

	always_ff @(posedge clk) begin
		if (qh_we) begin
			qh_used_m[qh_wa] <= !cmd.sweep;
			qh_slot_m[qh_wa] <= q_slot;
		end
		if (qh_re) begin
			qh_used_r <= qh_used_m[qh_ra];
			qh_slot_r <= qh_slot_m[qh_ra];
		end
	end

	// query slots
	always_ff @(posedge clk) begin
		if (cmd.qry_wr) begin
			qo_m[q_slot]    <= side_to;
			qn_m[q_slot]    <= QNW'(q_cnt_q);
			qlink_m[q_slot] <= qh_slot_r;
			qused_m[q_slot] <= qh_used_r;
		end
		if (cmd.q_rd) begin
			qo_r    <= qo_m[q_q];
			qn_r    <= qn_m[q_q];
			qlink_r <= qlink_m[q_q];
			qused_r <= qused_m[q_q];
		end
	end

	// visited flag and union-find parent
	logic           node_we, node_re;
	logic [NIW-1:0] node_wa, node_ra, node_wpar;

	assign node_we = cmd.sweep | cmd.init_rd | cmd.visit | cmd.cmp_wr | cmd.par_wr;
	always_comb begin
		if (cmd.sweep) begin
			node_wa   = sweep_q;
			node_wpar = sweep_q;
		end else if (cmd.init_rd) begin
			node_wa   = NIW'(1);
			node_wpar = NIW'(1);
		end else if (cmd.visit) begin
			node_wa   = v_q;
			node_wpar = v_q;
		end else if (cmd.cmp_wr) begin
			node_wa   = cx_q;
			node_wpar = r_q;
		end else begin
			node_wa   = x_q;
			node_wpar = stk_node_r;
		end
	end
	assign node_re = cmd.edge_take | cmd.q_take | cmd.root_step | cmd.cmp_rd;
	always_comb begin
		if (cmd.edge_take) node_ra = edge_v_r;
		else if (cmd.q_take) node_ra = qo_r;
		else if (cmd.root_step) node_ra = node_par_r;
		else node_ra = cx_q;
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_seen_m[node_wa] <= !cmd.sweep;
			node_par_m[node_wa]  <= node_wpar;
		end
		if (node_re) begin
			node_seen_r <= node_seen_m[node_ra];
			node_par_r  <= node_par_m[node_ra];
		end
	end

	// distance from the root
	logic           dist_re;
	logic [NIW-1:0] dist_ra;

	assign dist_re = cmd.edge_fetch | cmd.dx_rd | cmd.do_rd | cmd.dl_rd;
	always_comb begin
		if (cmd.edge_fetch || cmd.dx_rd) dist_ra = x_q;
		else if (cmd.do_rd) dist_ra = o_q;
		else dist_ra = r_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.init_rd || cmd.visit) begin
			dist_m[cmd.init_rd ? NIW'(1) : v_q] <= cmd.init_rd ? '0 : acc_q;
		end
		if (dist_re) dist_r <= dist_m[dist_ra];
	end

	// walk stack
	logic           stk_we;
	logic [NIW-1:0] stk_wa, stk_wnode;
	logic [EW-1:0]  stk_wedge;
	logic           stk_wmore;

	assign stk_we = cmd.init_wr | cmd.edge_take | cmd.push;
	always_comb begin
		if (cmd.init_wr) begin
			stk_wa    = '0;
			stk_wnode = NIW'(1);
			stk_wedge = head_idx_r;
			stk_wmore = head_used_r;
		end else if (cmd.edge_take) begin
			stk_wa    = stk_top1;
			stk_wnode = x_q;
			stk_wedge = edge_link_r;
			stk_wmore = edge_used_r;
		end else begin
			stk_wa    = NIW'(top_q);
			stk_wnode = v_q;
			stk_wedge = head_idx_r;
			stk_wmore = head_used_r;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_node_m[stk_wa] <= stk_wnode;
			stk_edge_m[stk_wa] <= stk_wedge;
			stk_more_m[stk_wa] <= stk_wmore;
		end
		if (cmd.stk_rd) begin
			stk_node_r <= stk_node_m[stk_top1];
			stk_edge_r <= stk_edge_m[stk_top1];
			stk_more_r <= stk_more_m[stk_top1];
		end
	end

	// answers
	always_ff @(posedge clk) begin
		if (cmd.ans_wr) ans_m[n_q] <= acc_q - {dist_r[DW-2:0], 1'b0};
		if (cmd.em_rd) ans_r <= ans_m[QNW'(em_i_q)];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q  <= '0;
			q_cnt_q     <= '0;
			sweep_q     <= '0;
			top_q       <= '0;
			ans_valid_q <= '0;
			em_i_q      <= '0;
			has_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				edge_cnt_q <= '0;
				q_cnt_q    <= '0;
			end
			if (cmd.clr_all || cmd.clr_valid) ans_valid_q <= '0;
			if (cmd.edge_wr) edge_cnt_q <= edge_cnt_q + ECW'(1);
			if (cmd.qry_wr && cmd.side_b) q_cnt_q <= q_cnt_q + QCW'(1);
			if (cmd.sweep) sweep_q <= status.sweep_last ? '0 : sweep_q + NIW'(1);
			if (cmd.init_wr) top_q <= TW'(1);
			if (cmd.push) top_q <= top_q + TW'(1);
			if (cmd.pop) top_q <= top_q - TW'(1);
			if (cmd.qh_take) has_q <= qh_used_r;
			if (cmd.q_take) has_q <= qused_r;
			if (cmd.ans_wr) ans_valid_q[n_q] <= 1'b1;
			if (cmd.em_init) em_i_q <= '0;
			if (cmd.em_ld) em_i_q <= em_i_q + QCW'(1);
			if (cmd.em_ld) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			a_q <= NIW'(in_a);
			b_q <= NIW'(in_b);
			w_q <= LB'(in_len);
		end
		if (cmd.top_ld) begin
			x_q <= stk_node_r;
			e_q <= stk_edge_r;
		end
		if (cmd.edge_take) begin
			v_q   <= edge_v_r;
			acc_q <= dist_r + DW'(edge_w_r);
		end
		if (cmd.qh_take) q_q <= qh_slot_r;
		if (cmd.q_take) begin
			o_q  <= qo_r;
			n_q  <= qn_r;
			q_q  <= qlink_r;
			r_q  <= qo_r;
			cx_q <= qo_r;
		end
		if (cmd.root_step) r_q <= node_par_r;
		if (cmd.cmp_wr) cx_q <= node_par_r;
		if (cmd.do_rd) acc_q <= dist_r;
		if (cmd.dl_rd) acc_q <= acc_q + dist_r;
		if (cmd.em_ld) begin
			out_idx_q  <= tpd_pkg::QIDX_W'(em_i_q);
			out_ans_q  <= ans_valid_q[QNW'(em_i_q)];
			out_dist_q <= ans_valid_q[QNW'(em_i_q)] ? ans_r : '0;
			out_last_q <= status.em_last;
		end
	end

	// status back to the controller
	assign a_ok      = {22'd0, in_a} < 32'(MAX_NODES);
	assign b_ok      = {22'd0, in_b} < 32'(MAX_NODES);
	assign edge_room = (32'(edge_cnt_q) + 32'd2) <= 32'(EDGE_SLOTS);
	assign q_room    = 32'(q_cnt_q) < 32'(MAX_QUERIES);

	always_comb begin
		status    = '0;
		status.op = s_tuser;
		case (s_tuser)
			tpd_pkg::OP_EDGE:  status.in_ok = a_ok && b_ok && edge_room;
			tpd_pkg::OP_QUERY: status.in_ok = a_ok && b_ok && q_room;
			default:           status.in_ok = 1'b1;
		endcase
		status.seen        = node_seen_r;
		status.parent_is_r = (node_par_r == r_q);
		status.cx_is_r     = (cx_q == r_q);
		status.more        = stk_more_r;
		status.top_full    = (top_q == TW'(MAX_NODES));
		status.top_zero    = (top_q == '0);
		status.has         = has_q;
		status.sweep_last  = (sweep_q == NIW'(MAX_NODES - 1));
		status.q_empty     = (q_cnt_q == '0);
		status.em_last     = ((em_i_q + QCW'(1)) == q_cnt_q);
		status.out_free    = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_dist_q, out_idx_q};
	assign m_tuser  = out_ans_q;
	assign m_tlast  = out_last_q;

	`ASSERT_ALWAYS(a_top_bound, clk, arst_n, top_q <= TW'(MAX_NODES))
	`ASSERT_ALWAYS(a_edge_bound, clk, arst_n, 32'(edge_cnt_q) <= 32'(EDGE_SLOTS))
	`ASSERT_ALWAYS(a_query_bound, clk, arst_n, 32'(q_cnt_q) <= 32'(MAX_QUERIES))
	`ASSERT_IMPLY(a_load_free, clk, arst_n, cmd.em_ld, !out_valid_q || m_tready)
	`ASSERT_IMPLY(a_push_room, clk, arst_n, cmd.push, top_q < TW'(MAX_NODES))

endmodule

// File: design/tree_path_distance_offline_lca.sv
`timescale 1ns / 1ps

// Tree path distances by offline lowest common ancestors. Each input beat carries a command in
// tuser: clear (empties the tree and the query list, then a clearing pass over all MAX_NODES
// entries), add edge, add query or run. Run first clears the visited flags, then walks the tree
// depth first from node 1 on a stack memory; when a node is finished, each query on it whose
// other node was reached is answered by root steps and compressed links, and the pace of all
// of it is set by the single read port of each store. It then sends one answer beat per loaded
// query in query order, reading the next answer only after the last one is loaded, tlast on
// the final one; a query whose node was not reached gives answered (tuser) low and distance 0.
// After reset the same clearing pass as for clear runs before the first beat.
module tree_path_distance_offline_lca #(
	parameter int MAX_NODES   = tpd_pkg::DEF_MAX_NODES,
	parameter int MAX_QUERIES = tpd_pkg::DEF_MAX_QUERIES,
	parameter int LENGTH_BITS = tpd_pkg::DEF_LENGTH_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// node_a [9:0], node_b [19:10], edge_length [35:20], zero fill [39:36]
	input  logic [tpd_pkg::IN_DATA_W-1:0]   s_tdata,
	// op [1:0]
	input  logic [tpd_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// query_index [5:0], distance [31:6]
	output logic [tpd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// answered [0]
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast
);

	tpd_pkg::cmd_t    walk_cmd, emit_cmd, cmd;
	tpd_pkg::status_t status;
	logic             emit_busy, walk_ready;

	tpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid && !emit_busy),
		.s_tready (walk_ready),
		.status   (status),
		.cmd      (walk_cmd)
	);

	tpd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_done (walk_cmd.em_init),
		.q_empty  (status.q_empty),
		.em_last  (status.em_last),
		.out_free (status.out_free),
		.busy     (emit_busy),
		.cmd      (emit_cmd)
	);

	assign cmd      = walk_cmd | emit_cmd;
	assign s_tready = walk_ready && !emit_busy;

	tpd_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_QUERIES (MAX_QUERIES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: tb/sv/tb_tree_path_distance_offline_lca.sv
`timescale 1ns / 1ps

module tb_tree_path_distance_offline_lca;

	localparam int NODES     = tpd_pkg::DEF_MAX_NODES;
	localparam int QUERIES   = tpd_pkg::DEF_MAX_QUERIES;
	localparam int SLOTS     = 2 * NODES;
	localparam int QSLOTS    = 2 * QUERIES;
	localparam int IDLE_MAX  = 200000;
	localparam int HOLD_LEN  = 400;

	typedef struct {
		logic [tpd_pkg::OP_W-1:0]   op;
		logic [tpd_pkg::NODE_W-1:0] a;
		logic [tpd_pkg::NODE_W-1:0] b;
		logic [tpd_pkg::LEN_W-1:0]  w;
	} cmd_beat_t;

	typedef struct {
		logic [tpd_pkg::QIDX_W-1:0] idx;
		logic [tpd_pkg::DIST_W-1:0] path_len;
		logic                       ans;
		logic                       last;
	} answer_t;

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           s_tvalid = 0;
	logic                           s_tready;
	logic [tpd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [tpd_pkg::OP_W-1:0]       s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 0;
	logic [tpd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [0:0]                     m_tuser;
	logic                           m_tlast;

	tree_path_distance_offline_lca uut (.*);

	always #10 clk = ~clk;

	// predictor state
	int adj_head[NODES];
	bit adj_used[NODES];
	int e_nb[SLOTS], e_w[SLOTS], e_link[SLOTS];
	bit e_more[SLOTS];
	int e_cnt;
	int uf_par[NODES];
	bit seen[NODES];
	int rdist[NODES];
	int qh[NODES];
	bit qh_used[NODES];
	int q_other[QSLOTS], q_num[QSLOTS], q_link[QSLOTS];
	bit q_more[QSLOTS];
	int q_cnt;
	int ans_dist[QUERIES];
	bit ans_ok[QUERIES];
	int stk_node[NODES], stk_edge[NODES];
	bit stk_more[NODES];

	cmd_beat_t pending[$];
	answer_t   expected_answers[$];
	cmd_beat_t cur;
	int        errors = 0, n_beats = 0, n_answers = 0, n_runs = 0;
	int        cyc = 0, idle_cyc = 0, hold = 0;
	bit        hold_done = 0;
	bit        calm;

	function automatic void add_arc(int from, int to, int w);
		e_nb[e_cnt] = to;
		e_w[e_cnt] = w;
		e_link[e_cnt] = adj_head[from];
		e_more[e_cnt] = adj_used[from];
		adj_head[from] = e_cnt;
		adj_used[from] = 1;
		e_cnt++;
	endfunction

	function automatic void add_qarc(int slot, int at, int other, int num);
		q_other[slot] = other;
		q_num[slot] = num;
		q_link[slot] = qh[at];
		q_more[slot] = qh_used[at];
		qh[at] = slot;
		qh_used[at] = 1;
	endfunction

	function automatic int find_root(int x);
		int r, g, nx;
		r = x;
		g = 0;
		while (uf_par[r] != r && g < NODES) begin
			r = uf_par[r] % NODES;
			g++;
		end
		g = 0;
		while (x != r && g < NODES) begin
			nx = uf_par[x] % NODES;
			uf_par[x] = r;
			x = nx;
			g++;
		end
		return r;
	endfunction

	function automatic void close_node(int x);
		bit has;
		int q, o, n, l;
		longint d;
		has = qh_used[x];
		q = qh[x];
		while (has) begin
			o = q_other[q];
			n = q_num[q];
			if (seen[o] && n < QUERIES) begin
				l = find_root(o);
				d = longint'(rdist[x]) + rdist[o] - 2 * longint'(rdist[l]);
				ans_dist[n] = int'(d & 64'h3FF_FFFF);
				ans_ok[n] = 1;
			end
			has = q_more[q];
			q = q_link[q];
		end
	endfunction

	function automatic void walk_and_answer();
		int top, x, e, v;
		answer_t r;
		foreach (seen[i]) seen[i] = 0;
		foreach (ans_ok[i]) ans_ok[i] = 0;
		seen[1] = 1;
		uf_par[1] = 1;
		rdist[1] = 0;
		stk_node[0] = 1;
		stk_edge[0] = adj_head[1];
		stk_more[0] = adj_used[1];
		top = 1;
		while (top > 0) begin
			x = stk_node[top-1];
			if (stk_more[top-1]) begin
				e = stk_edge[top-1];
				v = e_nb[e];
				stk_edge[top-1] = e_link[e];
				stk_more[top-1] = e_more[e];
				if (!seen[v] && top < NODES) begin
					seen[v] = 1;
					uf_par[v] = v;
					rdist[v] = (rdist[x] + e_w[e]) & 32'h3FF_FFFF;
					stk_node[top] = v;
					stk_edge[top] = adj_head[v];
					stk_more[top] = adj_used[v];
					top++;
				end
			end else begin
				close_node(x);
				top--;
				if (top > 0)
					uf_par[x] = stk_node[top-1];
			end
		end
		for (int i = 0; i < q_cnt; i++) begin
			r.idx = i[tpd_pkg::QIDX_W-1:0];
			r.path_len = ans_ok[i] ? ans_dist[i][tpd_pkg::DIST_W-1:0] : '0;
			r.ans = ans_ok[i];
			r.last = (i + 1 == q_cnt);
			expected_answers = {expected_answers, r};
		end
	endfunction

	function automatic void apply_command(cmd_beat_t c);
		case (c.op)
			tpd_pkg::OP_CLEAR: begin
				foreach (adj_used[i]) adj_used[i] = 0;
				foreach (qh_used[i]) qh_used[i] = 0;
				foreach (seen[i]) seen[i] = 0;
				foreach (ans_ok[i]) ans_ok[i] = 0;
				e_cnt = 0;
				q_cnt = 0;
			end
			tpd_pkg::OP_EDGE: begin
				if (e_cnt + 2 <= SLOTS) begin
					add_arc(c.a, c.b, c.w);
					add_arc(c.b, c.a, c.w);
				end
			end
			tpd_pkg::OP_QUERY: begin
				if (q_cnt < QUERIES) begin
					add_qarc(2 * q_cnt, c.a, c.b, q_cnt);
					add_qarc(2 * q_cnt + 1, c.b, c.a, q_cnt);
					q_cnt++;
				end
			end
			default: begin
				n_runs++;
				walk_and_answer();
			end
		endcase
	endfunction

	task automatic queue_cmd(logic [tpd_pkg::OP_W-1:0] op, int a, int b, int w);
		cmd_beat_t c;
		c.op = op;
		c.a = a[tpd_pkg::NODE_W-1:0];
		c.b = b[tpd_pkg::NODE_W-1:0];
		c.w = w[tpd_pkg::LEN_W-1:0];
		pending = {pending, c};
	endtask

	// clear, then a random tree on n_nodes nodes (now and then an extra edge) plus n_q queries, then one or two runs
	task automatic queue_scenario(int n_nodes, int n_q);
		int ids[$];
		int k, p;
		queue_cmd(tpd_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
		ids = {ids, (($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1023)) : 1)};
		for (k = 1; k < n_nodes; k++) begin
			ids = {ids, int'($urandom_range(0, 1023))};
			p = ids[$urandom_range(0, k-1)];
			if ($urandom_range(0, 1))
				queue_cmd(tpd_pkg::OP_EDGE, p, ids[k], $urandom);
			else
				queue_cmd(tpd_pkg::OP_EDGE, ids[k], p, $urandom_range(0, 15));
			if ($urandom_range(0, 19) == 0)
				queue_cmd(tpd_pkg::OP_EDGE, ids[k], ids[$urandom_range(0, k)], $urandom);
		end
		for (k = 0; k < n_q; k++) begin
			if ($urandom_range(0, 7) == 0)
				queue_cmd(tpd_pkg::OP_QUERY, $urandom_range(0, 1023),
					ids[$urandom_range(0, n_nodes-1)], 0);
			else
				queue_cmd(tpd_pkg::OP_QUERY, ids[$urandom_range(0, n_nodes-1)],
					ids[$urandom_range(0, n_nodes-1)], $urandom);
		end
		queue_cmd(tpd_pkg::OP_RUN, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 3) == 0) begin
			queue_cmd(tpd_pkg::OP_QUERY, ids[0], ids[n_nodes-1], 0);
			queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_command(cur);
				n_beats++;
			end
			if ((!s_tvalid || s_tready) && pending.size() > 0
				&& (calm || $urandom_range(0, 99) >= 14)) begin
				cur = pending.pop_front();
				s_tvalid <= 1;
				s_tuser <= cur.op;
				s_tdata <= {4'b0, cur.w, cur.b, cur.a};
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 0;
			end
		end
	end

	// receiver with one long hold-off during an answer read-out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (hold > 0) begin
			hold <= hold - 1;
			m_tready <= 0;
		end else if (!hold_done && m_tvalid && expected_answers.size() > 2) begin
			hold_done <= 1;
			hold <= HOLD_LEN;
			m_tready <= 0;
		end else begin
			m_tready <= calm || $urandom_range(0, 99) >= 14;
		end
	end

	// answer checker
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_answers++;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected answer beat idx=%0d dist=%0d answered=%0d last=%0d",
					$time, m_tdata[5:0], m_tdata[31:6], m_tuser[0], m_tlast);
				errors++;
			end else begin
				e = expected_answers.pop_front();
				if (m_tdata[5:0] !== e.idx) begin
					$display("%0t: query_index expected %0d got %0d", $time, e.idx, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[31:6] !== e.path_len) begin
					$display("%0t: distance (query %0d) expected %0d got %0d",
						$time, e.idx, e.path_len, m_tdata[31:6]);
					errors++;
				end
				if (m_tuser[0] !== e.ans) begin
					$display("%0t: answered (query %0d) expected %0d got %0d",
						$time, e.idx, e.ans, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last (query %0d) expected %0d got %0d",
						$time, e.idx, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		cyc++;
		calm = (cyc > 1500 && cyc < 4500);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= IDLE_MAX) begin
			$display("%0t: timeout, %0d answers still expected", $time, expected_answers.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int k;
		// directed: small tree 1-2-3, 1-1023, extreme weights, self-loop, duplicate
		queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		queue_cmd(tpd_pkg::OP_EDGE, 1, 2, 16'hFFFF);
		queue_cmd(tpd_pkg::OP_EDGE, 2, 3, 16'hFFFF);
		queue_cmd(tpd_pkg::OP_EDGE, 1, 1023, 0);
		queue_cmd(tpd_pkg::OP_EDGE, 3, 3, 7);
		queue_cmd(tpd_pkg::OP_EDGE, 2, 1, 5);
		queue_cmd(tpd_pkg::OP_EDGE, 700, 0, 9);
		queue_cmd(tpd_pkg::OP_QUERY, 3, 1023, 0);
		queue_cmd(tpd_pkg::OP_QUERY, 2, 2, 16'hFFFF);
		queue_cmd(tpd_pkg::OP_QUERY, 0, 3, 0);
		queue_cmd(tpd_pkg::OP_QUERY, 1023, 1, 0);
		queue_cmd(tpd_pkg::OP_RUN, 10'h3FF, 10'h3FF, 16'hFFFF);
		queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		queue_cmd(tpd_pkg::OP_CLEAR, 0, 0, 0);
		queue_cmd(tpd_pkg::OP_QUERY, 1, 1, 0);
		queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		// deep chain with maximal weights
		queue_cmd(tpd_pkg::OP_CLEAR, 0, 0, 0);
		for (k = 1; k < 40; k++)
			queue_cmd(tpd_pkg::OP_EDGE, k, k + 1, 16'hFFFF);
		queue_cmd(tpd_pkg::OP_QUERY, 40, 1, 0);
		queue_cmd(tpd_pkg::OP_QUERY, 20, 39, 0);
		queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		// fill the query store past capacity
		queue_cmd(tpd_pkg::OP_CLEAR, 0, 0, 0);
		queue_cmd(tpd_pkg::OP_EDGE, 1, 5, 3);
		queue_cmd(tpd_pkg::OP_EDGE, 1, 6, 4);
		for (k = 0; k < QUERIES + 3; k++)
			queue_cmd(tpd_pkg::OP_QUERY, (k % 3 == 0) ? 5 : 1, (k % 2) ? 6 : 0, 0);
		queue_cmd(tpd_pkg::OP_RUN, 0, 0, 0);
		// random trees, mostly small
		for (k = 0; k < 14; k++)
			queue_scenario($urandom_range(2, 12), $urandom_range(1, 6));
		queue_scenario(40, 15);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0);
		@(posedge clk);
		while (s_tvalid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d command beats in %0d runs, %0d answer beats checked",
			n_beats, n_runs, n_answers);
		$display("trees from 2 to 40 nodes, a full query store, unreached nodes, output stall");
		if (errors == 0 && expected_answers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/tpd_pkg.sv
design/tpd_ctrl.sv
design/tpd_emit.sv
design/tpd_datapath.sv
design/tree_path_distance_offline_lca.sv
tb/sv/tb_tree_path_distance_offline_lca.sv
